/* rtl/mws_pkg.sv */
// Shared constants for the maze walker step unit.
`default_nettype none

package mws_pkg;

    // Default geometry
    localparam int GRID_SIDE_DEF  = 16;
    localparam int DIST_LIMIT_DEF = 12;

    // Cell codes
    localparam int CELL_W = 3;
    localparam logic [CELL_W-1:0] CODE_FREE    = 3'd0;
    localparam logic [CELL_W-1:0] CODE_VISITED = 3'd1;
    localparam logic [CELL_W-1:0] CODE_WALL    = 3'd2;
    localparam logic [CELL_W-1:0] CODE_START   = 3'd3;
    localparam logic [CELL_W-1:0] CODE_FINISH  = 3'd4;

    // Request kinds
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_STEP    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Walk phases
    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_RETURN = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_FINISH_ROW = 2'd0;
    localparam logic [1:0] REG_FINISH_COL = 2'd1;
    localparam logic [1:0] REG_START_ROW  = 2'd2;
    localparam logic [1:0] REG_START_COL  = 2'd3;

    // Configuration reset values
    localparam logic [3:0] FINISH_ROW_RST = 4'd1;
    localparam logic [3:0] FINISH_COL_RST = 4'd7;
    localparam logic [3:0] START_ROW_RST  = 4'd7;
    localparam logic [3:0] START_COL_RST  = 4'd1;

endpackage

`default_nettype wire

/* rtl/mws_grid.sv */
// Grid cell store: one write port, one registered read port.
`default_nettype none

module mws_grid #(
    parameter int DEPTH = mws_pkg::GRID_SIDE_DEF * mws_pkg::GRID_SIDE_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [mws_pkg::CELL_W-1:0] wr_code,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    output logic      [mws_pkg::CELL_W-1:0] rd_code
);

    logic [mws_pkg::CELL_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_code;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_code <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/maze_walker_step_unit.sv */
// Maze walker step unit: top level with sequencer, shared passage judge and ports.
// Write, restart and ignored requests, and step requests once the walk is done,
// give their result in the cycle after acceptance. A walk step reads the grid
// store once per cycle through its single read port (current node, then the
// passages down, up, right, left), judges each passage in a single shared
// compare unit as its data returns, and then decides, writing back the passage
// it takes when it moves; the decision waits while the result register is full,
// and the input is not ready until the step's result is registered.
// The grid store has no reset; a cell must be written before it is read.
`default_nettype none

module maze_walker_step_unit #(
    parameter int GRID_SIDE  = mws_pkg::GRID_SIDE_DEF,
    parameter int DIST_LIMIT = mws_pkg::DIST_LIMIT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // cell_row[3:0], cell_col[7:4], cell_code[10:8]
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // pos_row[3:0], pos_col[7:4], phase[9:8],
                                        // moved[10], stuck[11]
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = ($clog2(GRID_SIDE) > 4) ? $clog2(GRID_SIDE) : 4;
    localparam int XW    = PW + 1;
    localparam int LW    = ((XW + 1) > $clog2(DIST_LIMIT + 1)) ? (XW + 1)
                                                                : $clog2(DIST_LIMIT + 1);
    localparam int CW    = mws_pkg::CELL_W;

    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_NODE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

    // Configuration registers
    logic [3:0] finish_row_reg, finish_col_reg, start_row_reg, start_col_reg;

    // Walker state
    state_t        state_reg, state_next;
    logic [PW-1:0] cur_row_reg, cur_row_next;
    logic [PW-1:0] cur_col_reg, cur_col_next;
    logic [1:0]    phase_reg, phase_next;

    // Passage pending in the read port
    logic [1:0]    pend_dir_reg, pend_dir_next;
    logic          pend_tin_reg, pend_tin_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic [PW-1:0] pend_trow_reg, pend_trow_next;
    logic [PW-1:0] pend_tcol_reg, pend_tcol_next;
    logic [LW-1:0] pend_len_reg, pend_len_next;

    // Running choice
    logic [CW-1:0] node_reg, node_next;
    logic          best_found_reg, best_found_next;
    logic [AW-1:0] best_addr_reg, best_addr_next;
    logic [PW-1:0] best_trow_reg, best_trow_next;
    logic [PW-1:0] best_tcol_reg, best_tcol_next;
    logic [1:0]    min_mark_reg, min_mark_next;
    logic [LW-1:0] min_len_reg, min_len_next;
    logic [2:0]    open_cnt_reg, open_cnt_next;

    // Result register
    logic       out_valid_reg, out_valid_next;
    logic [3:0] out_row_reg, out_row_next;
    logic [3:0] out_col_reg, out_col_next;
    logic [1:0] out_phase_reg, out_phase_next;
    logic       out_moved_reg, out_moved_next;
    logic       out_stuck_reg, out_stuck_next;

    // Grid ports
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [CW-1:0] wr_code, rd_code;

    // Request fields
    logic [1:0]  in_op;
    logic [3:0]  in_row, in_col;
    logic [CW-1:0] in_code;
    logic        accept, out_free, walk_req;

    assign in_op   = s_tuser;
    assign in_row  = s_tdata[3:0];
    assign in_col  = s_tdata[7:4];
    assign in_code = s_tdata[10:8];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign walk_req = (in_op == mws_pkg::OP_STEP)
                      && ((phase_reg == mws_pkg::PH_SEARCH) || (phase_reg == mws_pkg::PH_RETURN));

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finish_row_reg <= mws_pkg::FINISH_ROW_RST;
            finish_col_reg <= mws_pkg::FINISH_COL_RST;
            start_row_reg  <= mws_pkg::START_ROW_RST;
            start_col_reg  <= mws_pkg::START_COL_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[3:2])
                mws_pkg::REG_FINISH_ROW: finish_row_reg <= pwdata[3:0];
                mws_pkg::REG_FINISH_COL: finish_col_reg <= pwdata[3:0];
                mws_pkg::REG_START_ROW:  start_row_reg  <= pwdata[3:0];
                mws_pkg::REG_START_COL:  start_col_reg  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            mws_pkg::REG_FINISH_ROW: prdata[3:0] = finish_row_reg;
            mws_pkg::REG_FINISH_COL: prdata[3:0] = finish_col_reg;
            mws_pkg::REG_START_ROW:  prdata[3:0] = start_row_reg;
            mws_pkg::REG_START_COL:  prdata[3:0] = start_col_reg;
            default: prdata = '0;
        endcase
    end

    // Coordinates of the passage issued this cycle
    logic [1:0]    issue_dir;
    logic [XW-1:0] cr, cc, p_row, p_col, t_row, t_col;
    logic          no_under, t_in;
    logic [XW-1:0] fr, fc, d_row, d_col;
    logic [LW-1:0] issue_len;
    logic [AW-1:0] issue_addr;

    assign issue_dir = (state_reg == ST_NODE) ? DIR_DOWN : (pend_dir_reg + 2'd1);
    assign cr = XW'(cur_row_reg);
    assign cc = XW'(cur_col_reg);

    always_comb
    begin
        p_row    = cr;
        p_col    = cc;
        t_row    = cr;
        t_col    = cc;
        no_under = 1'b1;
        case (issue_dir)
            DIR_DOWN:
            begin
                p_row = cr + XW'(1);
                t_row = cr + XW'(2);
            end
            DIR_UP:
            begin
                p_row    = cr - XW'(1);
                t_row    = cr - XW'(2);
                no_under = (cr >= XW'(2));
            end
            DIR_RIGHT:
            begin
                p_col = cc + XW'(1);
                t_col = cc + XW'(2);
            end
            default:
            begin
                p_col    = cc - XW'(1);
                t_col    = cc - XW'(2);
                no_under = (cc >= XW'(2));
            end
        endcase
    end

    assign t_in = no_under && (t_row < XW'(GRID_SIDE)) && (t_col < XW'(GRID_SIDE));
    assign issue_addr = AW'(p_row * GRID_SIDE + p_col);

    // Manhattan distance from passage to finish
    assign fr = XW'(finish_row_reg);
    assign fc = XW'(finish_col_reg);
    assign d_row = (fr > p_row) ? (fr - p_row) : (p_row - fr);
    assign d_col = (fc > p_col) ? (fc - p_col) : (p_col - fc);
    assign issue_len = LW'(d_row) + LW'(d_col);

    // Current node address
    logic          node_in;
    logic [AW-1:0] node_addr;

    assign node_in   = (cr < XW'(GRID_SIDE)) && (cc < XW'(GRID_SIDE));
    assign node_addr = AW'(cr * GRID_SIDE + cc);

    // Shared passage judge
    logic [CW-1:0] code_eval;
    logic          open_eval, search_take, ret_take, take;

    assign code_eval   = pend_tin_reg ? rd_code : mws_pkg::CODE_WALL;
    assign open_eval   = pend_tin_reg && (code_eval != mws_pkg::CODE_WALL);
    assign search_take = open_eval
                         && ((code_eval < CW'(min_mark_reg))
                             || ((code_eval == CW'(min_mark_reg))
                                 && (pend_len_reg < min_len_reg)));
    assign ret_take    = !best_found_reg && pend_tin_reg
                         && (code_eval == mws_pkg::CODE_VISITED);
    assign take        = (phase_reg == mws_pkg::PH_SEARCH) ? search_take : ret_take;

    // Grid read requests
    assign rd_en   = (accept && walk_req) || (state_reg == ST_NODE)
                     || ((state_reg == ST_SCAN) && (pend_dir_reg != DIR_LEFT));
    assign rd_addr = (state_reg == ST_IDLE) ? node_addr : issue_addr;

    // Sequencer and next-state logic
    logic          dec_wr;
    logic [CW-1:0] dec_code;
    logic          cell_in;

    assign cell_in = (XW'(in_row) < XW'(GRID_SIDE)) && (XW'(in_col) < XW'(GRID_SIDE));

    always_comb
    begin
        state_next      = state_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        phase_next      = phase_reg;
        pend_dir_next   = pend_dir_reg;
        pend_tin_next   = pend_tin_reg;
        pend_addr_next  = pend_addr_reg;
        pend_trow_next  = pend_trow_reg;
        pend_tcol_next  = pend_tcol_reg;
        pend_len_next   = pend_len_reg;
        node_next       = node_reg;
        best_found_next = best_found_reg;
        best_addr_next  = best_addr_reg;
        best_trow_next  = best_trow_reg;
        best_tcol_next  = best_tcol_reg;
        min_mark_next   = min_mark_reg;
        min_len_next    = min_len_reg;
        open_cnt_next   = open_cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_phase_next  = out_phase_reg;
        out_moved_next  = out_moved_reg;
        out_stuck_next  = out_stuck_reg;
        dec_wr          = 1'b0;
        dec_code        = mws_pkg::CODE_VISITED;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (walk_req)
                    begin
                        pend_tin_next = node_in;
                        state_next    = ST_NODE;
                    end
                    else
                    begin
                        // Answered straight from the idle state
                        if (in_op == mws_pkg::OP_RESTART)
                        begin
                            cur_row_next = PW'(start_row_reg);
                            cur_col_next = PW'(start_col_reg);
                            phase_next   = mws_pkg::PH_SEARCH;
                        end
                        out_valid_next = 1'b1;
                        out_row_next   = cur_row_next[3:0];
                        out_col_next   = cur_col_next[3:0];
                        out_phase_next = phase_next;
                        out_moved_next = 1'b0;
                        out_stuck_next = 1'b0;
                    end
                end
            end
            ST_NODE:
            begin
                node_next       = code_eval;
                best_found_next = 1'b0;
                min_mark_next   = 2'd2;
                min_len_next    = LW'(DIST_LIMIT);
                open_cnt_next   = '0;
                pend_dir_next   = issue_dir;
                pend_tin_next   = t_in;
                pend_addr_next  = issue_addr;
                pend_trow_next  = PW'(t_row);
                pend_tcol_next  = PW'(t_col);
                pend_len_next   = issue_len;
                state_next      = ST_SCAN;
            end
            ST_SCAN:
            begin
                // Judge the returned passage
                open_cnt_next = open_cnt_reg + {2'b00, open_eval};
                if (take)
                begin
                    best_found_next = 1'b1;
                    best_addr_next  = pend_addr_reg;
                    best_trow_next  = pend_trow_reg;
                    best_tcol_next  = pend_tcol_reg;
                    min_mark_next   = code_eval[1:0];
                    min_len_next    = pend_len_reg;
                end
                // Issue the next passage
                if (pend_dir_reg == DIR_LEFT)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    pend_dir_next  = issue_dir;
                    pend_tin_next  = t_in;
                    pend_addr_next = issue_addr;
                    pend_trow_next = PW'(t_row);
                    pend_tcol_next = PW'(t_col);
                    pend_len_next  = issue_len;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    out_moved_next = 1'b0;
                    out_stuck_next = 1'b0;
                    if (phase_reg == mws_pkg::PH_SEARCH)
                    begin
                        if ((node_reg == mws_pkg::CODE_FINISH) || !best_found_reg)
                        begin
                            phase_next = mws_pkg::PH_RETURN;
                        end
                        else
                        begin
                            // Dead end off the start gets walled
                            dec_wr   = 1'b1;
                            dec_code = ((open_cnt_reg < 3'd2)
                                        && (node_reg != mws_pkg::CODE_START))
                                       ? mws_pkg::CODE_WALL : mws_pkg::CODE_VISITED;
                            cur_row_next   = best_trow_reg;
                            cur_col_next   = best_tcol_reg;
                            out_moved_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (node_reg == mws_pkg::CODE_START)
                        begin
                            phase_next = mws_pkg::PH_DONE;
                        end
                        else if (best_found_reg)
                        begin
                            dec_wr         = 1'b1;
                            dec_code       = mws_pkg::CODE_WALL;
                            cur_row_next   = best_trow_reg;
                            cur_col_next   = best_tcol_reg;
                            out_moved_next = 1'b1;
                        end
                        else
                        begin
                            out_stuck_next = 1'b1;
                        end
                    end
                    out_valid_next = 1'b1;
                    out_row_next   = cur_row_next[3:0];
                    out_col_next   = cur_col_next[3:0];
                    out_phase_next = phase_next;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Grid write requests
    assign wr_en   = (accept && (in_op == mws_pkg::OP_WRITE) && cell_in) || dec_wr;
    assign wr_addr = dec_wr ? best_addr_reg : AW'(XW'(in_row) * GRID_SIDE + XW'(in_col));
    assign wr_code = dec_wr ? dec_code : in_code;

    mws_grid #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_grid (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_code (wr_code),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_code (rd_code)
    );

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_row_reg    <= PW'(mws_pkg::START_ROW_RST);
            cur_col_reg    <= PW'(mws_pkg::START_COL_RST);
            phase_reg      <= mws_pkg::PH_SEARCH;
            out_valid_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            pend_dir_reg   <= DIR_DOWN;
            pend_tin_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
            best_found_reg <= best_found_next;
            pend_dir_reg   <= pend_dir_next;
            pend_tin_reg   <= pend_tin_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        pend_trow_reg <= pend_trow_next;
        pend_tcol_reg <= pend_tcol_next;
        pend_len_reg  <= pend_len_next;
        node_reg      <= node_next;
        best_addr_reg <= best_addr_next;
        best_trow_reg <= best_trow_next;
        best_tcol_reg <= best_tcol_next;
        min_mark_reg  <= min_mark_next;
        min_len_reg   <= min_len_next;
        open_cnt_reg  <= open_cnt_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_phase_reg <= out_phase_next;
        out_moved_reg <= out_moved_next;
        out_stuck_reg <= out_stuck_next;
    end

    // Result stream
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_stuck_reg, out_moved_reg, out_phase_reg,
                       out_col_reg, out_row_reg};

    // Checks
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && walk_req) |=> !s_tready)
        else $error("second request taken while a walk step is in progress");

    a_moved_or_stuck: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_moved_reg && out_stuck_reg))
        else $error("result both moved and stuck");

    a_done_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_phase_reg == mws_pkg::PH_DONE)) |-> !out_moved_reg)
        else $error("walker moved in done phase");

    a_move_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_moved_reg) |-> ((XW'(cur_row_reg) < XW'(GRID_SIDE))
                                         && (XW'(cur_col_reg) < XW'(GRID_SIDE))))
        else $error("walker moved outside the grid");

endmodule

`default_nettype wire
